// ===== rtl/core/utf8_to_code_point_decoder_macros.svh =====
// Assertion macros shared by the UTF-8 decoder RTL.
`ifndef UTF8_TO_CODE_POINT_DECODER_MACROS_SVH
`define UTF8_TO_CODE_POINT_DECODER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define U8DEC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define U8DEC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/u8dec_pkg.sv =====
// Types, constants and helper functions for the UTF-8 decoder.
package u8dec_pkg;

	localparam int unsigned AccW = 26;
	localparam int unsigned CpW  = 21;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       string_end;
	} in_item_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic [2:0]  byte_count;
		logic        truncated;
	} out_item_t;

	localparam logic [AccW-1:0] Offset2 = 26'h0003080;
	localparam logic [AccW-1:0] Offset3 = 26'h00E2080;
	localparam logic [AccW-1:0] Offset4 = 26'h3C82080;

	localparam logic [7:0] AsciiMax  = 8'h7F;
	localparam logic [7:0] Lead2Mask = 8'hE0;
	localparam logic [7:0] Lead2Code = 8'hC0;
	localparam logic [7:0] Lead3Mask = 8'hF0;
	localparam logic [7:0] Lead3Code = 8'hE0;
	localparam logic [7:0] Lead4Mask = 8'hF8;
	localparam logic [7:0] Lead4Code = 8'hF0;

	// Any lead that is not a valid multi-byte lead counts as a single byte.
	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd1;
		if (b <= AsciiMax) begin
			len = 3'd1;
		end else if ((b & Lead2Mask) == Lead2Code) begin
			len = 3'd2;
		end else if ((b & Lead3Mask) == Lead3Code) begin
			len = 3'd3;
		end else if ((b & Lead4Mask) == Lead4Code) begin
			len = 3'd4;
		end
		return len;
	endfunction

	function automatic logic [AccW-1:0] len_offset(input logic [2:0] n);
		logic [AccW-1:0] off;
		unique case (n)
			3'd2:    off = Offset2;
			3'd3:    off = Offset3;
			3'd4:    off = Offset4;
			default: off = '0;
		endcase
		return off;
	endfunction

endpackage

// ===== rtl/core/utf8_to_code_point_decoder.sv =====
// UTF-8 decoder: takes one byte per transaction and returns one code point per
// character. A byte may be accepted in every clock cycle while byte_stall is
// low; each byte passes an input register and then the decode logic, which
// updates the character state and loads the result register. The final byte
// of a character is held in the input register, and its result is loaded into
// the result register, which drives cp_valid, as that byte moves on. byte_stall
// is raised only while the input register holds a byte that yields a result
// and the result register is full and stalled. A zero byte ends the string and
// produces nothing by itself; a pending character cut short by it or by
// string_end is returned with truncated set.
`include "utf8_to_code_point_decoder_macros.svh"

module utf8_to_code_point_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  u8dec_pkg::in_item_t   byte_data,
	output logic                  cp_valid,
	input  logic                  cp_stall,
	output u8dec_pkg::out_item_t  cp_data
);

	logic                       valid_s1;
	u8dec_pkg::in_item_t        data_s1;

	logic [u8dec_pkg::AccW-1:0] acc_q;
	logic [2:0]                 exp_q;
	logic [2:0]                 taken_q;

	logic                       out_valid_q;
	u8dec_pkg::out_item_t       out_data_q;

	logic                       pending;
	logic                       is_zero;
	logic [u8dec_pkg::AccW-1:0] acc_new;
	logic [2:0]                 exp_new;
	logic [2:0]                 taken_new;
	logic                       emit;
	logic                       trunc;
	logic [u8dec_pkg::AccW-1:0] diff;
	logic                       advance;
	logic                       load_s1;

	// Decode of the item held in the input register against the pending state.
	always_comb begin
		pending   = (taken_q != 3'd0);
		is_zero   = (data_s1.data_byte == 8'h00);
		acc_new   = acc_q;
		exp_new   = exp_q;
		taken_new = taken_q;
		emit      = 1'b0;
		trunc     = 1'b0;
		if (is_zero) begin
			emit  = pending;
			trunc = 1'b1;
		end else begin
			if (!pending) begin
				exp_new   = u8dec_pkg::lead_length(data_s1.data_byte);
				acc_new   = {{(u8dec_pkg::AccW-8){1'b0}}, data_s1.data_byte};
				taken_new = 3'd1;
			end else begin
				acc_new   = {acc_q[u8dec_pkg::AccW-7:0], 6'b0}
					+ {{(u8dec_pkg::AccW-8){1'b0}}, data_s1.data_byte};
				taken_new = taken_q + 3'd1;
			end
			if (taken_new >= exp_new) begin
				emit = 1'b1;
			end else if (data_s1.string_end) begin
				emit  = 1'b1;
				trunc = 1'b1;
			end
		end
		diff = acc_new - u8dec_pkg::len_offset(taken_new);
	end

	// The input register moves on unless it holds a result and the result
	// register is full and stalled.
	assign advance    = !emit || !out_valid_q || !cp_stall;
	assign byte_stall = valid_s1 && !advance;
	assign load_s1    = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			data_s1 <= byte_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			exp_q   <= 3'd0;
			taken_q <= 3'd0;
		end else if (valid_s1 && advance) begin
			if (emit || is_zero) begin
				acc_q   <= '0;
				exp_q   <= 3'd0;
				taken_q <= 3'd0;
			end else begin
				acc_q   <= acc_new;
				exp_q   <= exp_new;
				taken_q <= taken_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && emit && advance) begin
			out_valid_q <= 1'b1;
		end else if (!cp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && emit && advance) begin
			out_data_q.code_point <= diff[u8dec_pkg::CpW-1:0];
			out_data_q.byte_count <= taken_new;
			out_data_q.truncated  <= trunc;
		end
	end

	assign cp_valid = out_valid_q;
	assign cp_data  = out_data_q;

	`U8DEC_ASSERT_ALWAYS(a_pending_short, (taken_q == 3'd0) || (taken_q < exp_q), "pending count reached expected length")
	`U8DEC_ASSERT_ALWAYS(a_count_range, !cp_valid || (cp_data.byte_count >= 3'd1 && cp_data.byte_count <= 3'd4 && (!cp_data.truncated || cp_data.byte_count <= 3'd3)), "result byte count out of range")
	`U8DEC_ASSERT_NEXT(a_zero_idles, valid_s1 && advance && (data_s1.data_byte == 8'h00), taken_q == 3'd0, "zero byte left a character pending")

endmodule
